// ===== rtl/befg_pkg.sv =====
package befg_pkg;

    localparam int unsigned RegCount = 6;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 48;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ROT_X    = 3'd0,
        REG_ROT_Y    = 3'd1,
        REG_ROT_Z    = 3'd2,
        REG_OFF_I    = 3'd3,
        REG_OFF_J    = 3'd4,
        REG_INV_LEN  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] axial_force;
        logic signed [31:0] moment_z_start;
        logic signed [31:0] moment_z_end;
        logic signed [31:0] moment_y_start;
        logic signed [31:0] moment_y_end;
        logic signed [31:0] torque;
        logic signed [31:0] fixed_axial_start;
        logic signed [31:0] fixed_shear_y_start;
        logic signed [31:0] fixed_shear_y_end;
        logic signed [31:0] fixed_shear_z_start;
        logic signed [31:0] fixed_shear_z_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] force_start_x;
        logic signed [31:0] force_start_y;
        logic signed [31:0] force_start_z;
        logic signed [31:0] couple_start_x;
        logic signed [31:0] couple_start_y;
        logic signed [31:0] couple_start_z;
        logic signed [31:0] force_end_x;
        logic signed [31:0] force_end_y;
        logic signed [31:0] force_end_z;
        logic signed [31:0] couple_end_x;
        logic signed [31:0] couple_end_y;
        logic signed [31:0] couple_end_z;
    } t_out_beat;

    typedef struct packed {
        logic [47:0] rot_x;
        logic [47:0] rot_y;
        logic [47:0] rot_z;
        logic [47:0] off_i;
        logic [47:0] off_j;
        logic [31:0] inv_len;
    } t_cfg;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pick16(input logic [47:0] r,
                                                  input logic [1:0] k);
        logic signed [15:0] v;
        case (k)
            2'd0:    v = r[15:0];
            2'd1:    v = r[31:16];
            2'd2:    v = r[47:32];
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/befg_if.sv =====
interface befg_in_if;
    logic                 valid;
    logic                 ready;
    befg_pkg::t_in_beat   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface befg_out_if;
    logic                 valid;
    logic                 ready;
    befg_pkg::t_out_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/beam_end_force_to_global.sv =====
// Path: befg_local stages (length product, rounding), then befg_node stages.
// Throughput: one beat per cycle while the output is empty or taken; the whole
// pipeline advances together, and the output register holds a finished beat while the input side waits.
// Reset (synchronous, active low) empties the pipeline; cosine and offset
// registers clear to zero, inv_length returns to 1.0 (Q16.16).
module beam_end_force_to_global (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [befg_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [befg_pkg::CfgDataW-1:0] i_cfg_data,
    befg_in_if.sink                    s_in,
    befg_out_if.source                 m_out
);
    befg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rot_x: '0, rot_y: '0, rot_z: '0, off_i: '0, off_j: '0,
                       inv_len: 32'h0001_0000};
        end else if (i_cfg_we) begin
            case (befg_pkg::t_reg_idx'(i_cfg_idx))
                befg_pkg::REG_ROT_X:   r_cfg.rot_x   <= i_cfg_data;
                befg_pkg::REG_ROT_Y:   r_cfg.rot_y   <= i_cfg_data;
                befg_pkg::REG_ROT_Z:   r_cfg.rot_z   <= i_cfg_data;
                befg_pkg::REG_OFF_I:   r_cfg.off_i   <= i_cfg_data;
                befg_pkg::REG_OFF_J:   r_cfg.off_j   <= i_cfg_data;
                befg_pkg::REG_INV_LEN: r_cfg.inv_len <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves when the last stage is empty or being drained
    logic w_en;
    assign w_en       = !m_out.valid || m_out.ready;
    assign s_in.ready = w_en;

    logic               w_lv;
    logic signed [31:0] w_fs [3], w_ms [3], w_fe [3], w_me [3];

    befg_local u_local (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_in.valid),
        .i_data   (s_in.data),
        .i_inv_len(r_cfg.inv_len),
        .o_valid  (w_lv),
        .o_fs     (w_fs),
        .o_ms     (w_ms),
        .o_fe     (w_fe),
        .o_me     (w_me)
    );

    logic [47:0] w_rot [3];
    assign w_rot[0] = r_cfg.rot_x;
    assign w_rot[1] = r_cfg.rot_y;
    assign w_rot[2] = r_cfg.rot_z;

    logic               w_vs, w_ve;
    logic signed [31:0] w_gfs [3], w_gms [3], w_gfe [3], w_gme [3];

    befg_node u_start (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_lv),
        .i_f(w_fs), .i_m(w_ms), .i_rot(w_rot), .i_off(r_cfg.off_i),
        .o_valid(w_vs), .o_f(w_gfs), .o_m(w_gms)
    );

    befg_node u_end (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_lv),
        .i_f(w_fe), .i_m(w_me), .i_rot(w_rot), .i_off(r_cfg.off_j),
        .o_valid(w_ve), .o_f(w_gfe), .o_m(w_gme)
    );

    assign m_out.valid = w_vs;
    assign m_out.data.force_start_x  = w_gfs[0];
    assign m_out.data.force_start_y  = w_gfs[1];
    assign m_out.data.force_start_z  = w_gfs[2];
    assign m_out.data.couple_start_x = w_gms[0];
    assign m_out.data.couple_start_y = w_gms[1];
    assign m_out.data.couple_start_z = w_gms[2];
    assign m_out.data.force_end_x    = w_gfe[0];
    assign m_out.data.force_end_y    = w_gfe[1];
    assign m_out.data.force_end_z    = w_gfe[2];
    assign m_out.data.couple_end_x   = w_gme[0];
    assign m_out.data.couple_end_y   = w_gme[1];
    assign m_out.data.couple_end_z   = w_gme[2];

    // both node pipes must carry the same beat
    a_nodes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vs == w_ve) else $error("node pipes out of step");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("output beat changed under stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready) else $error("input blocked on empty output");
endmodule

// ===== rtl/befg_local.sv =====
// Local end forces: two stages (length product, then rounding/saturation).
module befg_local (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  befg_pkg::t_in_beat   i_data,
    input  logic [31:0]          i_inv_len,
    output logic                 o_valid,
    output logic signed [31:0]   o_fs [3],
    output logic signed [31:0]   o_ms [3],
    output logic signed [31:0]   o_fe [3],
    output logic signed [31:0]   o_me [3]
);
    // stage A: magnitudes times 1/L
    logic               r_a_valid;
    befg_pkg::t_in_beat r_a_data;
    logic [64:0]        r_py, r_pz;
    logic               r_ny, r_nz;
    logic signed [32:0] n_sy, n_sz;
    logic [32:0]        n_my, n_mz;

    always_comb begin
        n_sy = 33'(i_data.moment_z_start) + 33'(i_data.moment_z_end);
        n_sz = 33'(i_data.moment_y_start) + 33'(i_data.moment_y_end);
        n_my = n_sy[32] ? 33'(-n_sy) : 33'(n_sy);
        n_mz = n_sz[32] ? 33'(-n_sz) : 33'(n_sz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_data <= i_data;
            r_py     <= 65'(n_my) * 65'(i_inv_len);
            r_pz     <= 65'(n_mz) * 65'(i_inv_len);
            r_ny     <= n_sy[32];
            r_nz     <= n_sz[32];
        end
    end

    // stage B: round half away, saturate, assemble local triads
    logic [64:0]        n_ry, n_rz;
    logic signed [63:0] n_vy, n_vz;
    always_comb begin
        n_ry = (r_py + 65'h8000) >> 16;
        n_rz = (r_pz + 65'h8000) >> 16;
        n_vy = 64'(befg_pkg::sat32(r_ny ? -$signed(n_ry[63:0]) : $signed(n_ry[63:0])));
        n_vz = -64'(befg_pkg::sat32(r_nz ? -$signed(n_rz[63:0]) : $signed(n_rz[63:0])));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_a_valid;
        end
        if (i_en) begin
            o_fs[0] <= befg_pkg::sat32(-64'(r_a_data.axial_force)
                                      + 64'(r_a_data.fixed_axial_start));
            o_fs[1] <= befg_pkg::sat32(n_vy + 64'(r_a_data.fixed_shear_y_start));
            o_fs[2] <= befg_pkg::sat32(n_vz + 64'(r_a_data.fixed_shear_z_start));
            o_ms[0] <= befg_pkg::sat32(-64'(r_a_data.torque));
            o_ms[1] <= r_a_data.moment_y_start;
            o_ms[2] <= r_a_data.moment_z_start;
            o_fe[0] <= r_a_data.axial_force;
            o_fe[1] <= befg_pkg::sat32(-n_vy + 64'(r_a_data.fixed_shear_y_end));
            o_fe[2] <= befg_pkg::sat32(-n_vz + 64'(r_a_data.fixed_shear_z_end));
            o_me[0] <= r_a_data.torque;
            o_me[1] <= r_a_data.moment_y_end;
            o_me[2] <= r_a_data.moment_z_end;
        end
    end
endmodule

// ===== rtl/befg_node.sv =====
// One node: rotate force and moment triads, add offset cross product.
// Stages: products, rotated sums, cross products, final sum.
module befg_node (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_f [3],
    input  logic signed [31:0]  i_m [3],
    input  logic [47:0]         i_rot [3],
    input  logic [47:0]         i_off,
    output logic                o_valid,
    output logic signed [31:0]  o_f [3],
    output logic signed [31:0]  o_m [3]
);
    logic [3:0] r_v;

    // stage 1: 18 products c(i,j)*local(i)
    logic signed [47:0] r_pf [3][3];
    logic signed [47:0] r_pm [3][3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pf[j][i] <= 48'(befg_pkg::pick16(i_rot[i], 2'(j))) * 48'(i_f[i]);
                    r_pm[j][i] <= 48'(befg_pkg::pick16(i_rot[i], 2'(j))) * 48'(i_m[i]);
                end
            end
        end
    end

    // stage 2: sum, shift by 14 rounding up at half
    logic signed [49:0] n_sf [3], n_sm [3];
    logic signed [31:0] r_fs [3];
    logic signed [35:0] r_mr [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sf[j] = 50'(r_pf[j][0]) + 50'(r_pf[j][1]) + 50'(r_pf[j][2]) + 50'sd8192;
            n_sm[j] = 50'(r_pm[j][0]) + 50'(r_pm[j][1]) + 50'(r_pm[j][2]) + 50'sd8192;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_fs[j] <= befg_pkg::sat32(64'(n_sf[j] >>> 14));
                r_mr[j] <= 36'(n_sm[j] >>> 14);
            end
        end
    end

    // stage 3: cross products o x F
    logic signed [47:0] r_cp [3][2];
    logic signed [31:0] r_f3 [3];
    logic signed [35:0] r_m3 [3];
    logic signed [15:0] n_o [3];
    always_comb begin
        for (int k = 0; k < 3; k++) n_o[k] = befg_pkg::pick16(i_off, 2'(k));
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cp[0][0] <= 48'(n_o[1]) * 48'(r_fs[2]);
            r_cp[0][1] <= 48'(n_o[2]) * 48'(r_fs[1]);
            r_cp[1][0] <= 48'(n_o[2]) * 48'(r_fs[0]);
            r_cp[1][1] <= 48'(n_o[0]) * 48'(r_fs[2]);
            r_cp[2][0] <= 48'(n_o[0]) * 48'(r_fs[1]);
            r_cp[2][1] <= 48'(n_o[1]) * 48'(r_fs[0]);
            r_f3 <= r_fs;
            r_m3 <= r_mr;
        end
    end

    // stage 4: round, add, saturate
    logic signed [48:0] n_c [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c[k] = 49'(r_cp[k][0]) - 49'(r_cp[k][1]) + 49'sd128;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                o_f[k] <= r_f3[k];
                o_m[k] <= befg_pkg::sat32(64'(r_m3[k]) + 64'(n_c[k] >>> 8));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end
    assign o_valid = r_v[3];
endmodule

// ===== test/beam_end_force_to_global_tb.sv =====
`timescale 1ns / 1ps

module beam_end_force_to_global_tb;

    // Q16.16 force path, Q2.14 cosines, Q8.8 offsets; one result beat per input beat
    class end_force_board;
        befg_pkg::t_out_beat pending[$];
        bit        failed;
        logic [47:0] rot[3];
        logic [47:0] off_i, off_j;
        logic [31:0] inv_len;

        function new();
            failed = 0;
            rot[0] = '0; rot[1] = '0; rot[2] = '0;
            off_i = '0; off_j = '0; inv_len = 32'd65536;
        endfunction

        function void set_reg(befg_pkg::t_reg_idx idx, logic [47:0] val);
            case (idx)
                befg_pkg::REG_ROT_X:   rot[0] = val;
                befg_pkg::REG_ROT_Y:   rot[1] = val;
                befg_pkg::REG_ROT_Z:   rot[2] = val;
                befg_pkg::REG_OFF_I:   off_i = val;
                befg_pkg::REG_OFF_J:   off_j = val;
                befg_pkg::REG_INV_LEN: inv_len = val[31:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint cos_of(logic [47:0] r, int k);
            logic signed [15:0] c;
            c = r[16*k +: 16];
            return longint'(c);
        endfunction

        // floor((v + half) >> sh)
        function longint round_up_shift(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        // shear from end moments, rounding half away from zero
        function longint shear_of(longint s);
            logic [63:0] mag;
            longint r;
            mag = (s < 0) ? -s : s;
            r = longint'((mag * {32'd0, inv_len} + 64'h8000) >> 16);
            return clip32(s < 0 ? -r : r);
        endfunction

        function void node_globals(longint f[3], longint m[3], logic [47:0] offr,
                                   output longint o[6]);
            longint acc, fr[3], mr[3], ff[3], ov[3], cr[3];
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += cos_of(rot[i], j) * f[i];
                fr[j] = round_up_shift(acc, 14);
                acc = 0;
                for (int i = 0; i < 3; i++) acc += cos_of(rot[i], j) * m[i];
                mr[j] = round_up_shift(acc, 14);
                ff[j] = clip32(fr[j]);
                ov[j] = cos_of(offr, j);
            end
            cr[0] = ov[1] * ff[2] - ov[2] * ff[1];
            cr[1] = ov[2] * ff[0] - ov[0] * ff[2];
            cr[2] = ov[0] * ff[1] - ov[1] * ff[0];
            for (int k = 0; k < 3; k++) begin
                o[k] = ff[k];
                o[3 + k] = clip32(mr[k] + round_up_shift(cr[k], 8));
            end
        endfunction

        function void note_input(befg_pkg::t_in_beat b);
            longint vy, vz, fs[3], ms[3], fe[3], me[3], os[6], oe[6];
            befg_pkg::t_out_beat e;
            vy = shear_of(longint'(b.moment_z_start) + longint'(b.moment_z_end));
            vz = -shear_of(longint'(b.moment_y_start) + longint'(b.moment_y_end));
            fs[0] = clip32(-longint'(b.axial_force) + longint'(b.fixed_axial_start));
            fs[1] = clip32(vy + longint'(b.fixed_shear_y_start));
            fs[2] = clip32(vz + longint'(b.fixed_shear_z_start));
            ms[0] = clip32(-longint'(b.torque));
            ms[1] = b.moment_y_start;
            ms[2] = b.moment_z_start;
            fe[0] = b.axial_force;
            fe[1] = clip32(-vy + longint'(b.fixed_shear_y_end));
            fe[2] = clip32(-vz + longint'(b.fixed_shear_z_end));
            me[0] = b.torque;
            me[1] = b.moment_y_end;
            me[2] = b.moment_z_end;
            node_globals(fs, ms, off_i, os);
            node_globals(fe, me, off_j, oe);
            e.force_start_x = os[0][31:0]; e.force_start_y = os[1][31:0];
            e.force_start_z = os[2][31:0]; e.couple_start_x = os[3][31:0];
            e.couple_start_y = os[4][31:0]; e.couple_start_z = os[5][31:0];
            e.force_end_x = oe[0][31:0]; e.force_end_y = oe[1][31:0];
            e.force_end_z = oe[2][31:0]; e.couple_end_x = oe[3][31:0];
            e.couple_end_y = oe[4][31:0]; e.couple_end_z = oe[5][31:0];
            pending.push_back(e);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
                failed = 1;
            end
        endfunction

        function void check_result(befg_pkg::t_out_beat a);
            befg_pkg::t_out_beat e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                failed = 1;
                return;
            end
            e = pending.pop_front();
            cmp("force_start_x", e.force_start_x, a.force_start_x);
            cmp("force_start_y", e.force_start_y, a.force_start_y);
            cmp("force_start_z", e.force_start_z, a.force_start_z);
            cmp("couple_start_x", e.couple_start_x, a.couple_start_x);
            cmp("couple_start_y", e.couple_start_y, a.couple_start_y);
            cmp("couple_start_z", e.couple_start_z, a.couple_start_z);
            cmp("force_end_x", e.force_end_x, a.force_end_x);
            cmp("force_end_y", e.force_end_y, a.force_end_y);
            cmp("force_end_z", e.force_end_z, a.force_end_z);
            cmp("couple_end_x", e.couple_end_x, a.couple_end_x);
            cmp("couple_end_y", e.couple_end_y, a.couple_end_y);
            cmp("couple_end_z", e.couple_end_z, a.couple_end_z);
        endfunction
    endclass

    localparam int WatchdogLimit = 2000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [befg_pkg::CfgIdxW-1:0] i_cfg_idx = '0;
    logic [befg_pkg::CfgDataW-1:0] i_cfg_data = '0;

    befg_in_if  in_ch();
    befg_out_if out_ch();

    beam_end_force_to_global u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    end_force_board board = new();
    int  idle_cycles = 0;
    bit  sink_on = 0;
    bit  quiet_phase = 0;   // no random gaps on either side while set

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    // result side: random stall before each beat, checked at the edge it lands;
    // ready stays high across beats when the drawn stall is zero
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (!sink_on) begin
                @(posedge i_clk);
            end else begin
                gap = quiet_phase ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    out_ch.ready <= 0;
                    repeat (gap) @(posedge i_clk);
                end
                out_ch.ready <= 1;
                do @(posedge i_clk); while (!out_ch.valid);
                board.check_result(out_ch.data);
            end
        end
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(befg_pkg::t_reg_idx idx, logic [47:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.set_reg(idx, val);
    endtask

    // out-of-range index must be ignored
    task automatic write_bad_index();
        i_cfg_we <= 1;
        i_cfg_idx <= 3'd7;
        i_cfg_data <= {48{1'b1}};
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_beat(befg_pkg::t_in_beat b);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(b);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            3: return $signed($urandom_range(0, 8'hFF)) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic befg_pkg::t_in_beat rand_beat();
        befg_pkg::t_in_beat b;
        b.axial_force = rand_word(); b.moment_z_start = rand_word();
        b.moment_z_end = rand_word(); b.moment_y_start = rand_word();
        b.moment_y_end = rand_word(); b.torque = rand_word();
        b.fixed_axial_start = rand_word(); b.fixed_shear_y_start = rand_word();
        b.fixed_shear_y_end = rand_word(); b.fixed_shear_z_start = rand_word();
        b.fixed_shear_z_end = rand_word();
        return b;
    endfunction

    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h4000;    // 1.0 in Q2.14
            3: return 16'hC000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_triple();
        return {rand_half(), rand_half(), rand_half()};
    endfunction

    task automatic random_config();
        write_reg(befg_pkg::REG_ROT_X, rand_triple());
        write_reg(befg_pkg::REG_ROT_Y, rand_triple());
        write_reg(befg_pkg::REG_ROT_Z, rand_triple());
        write_reg(befg_pkg::REG_OFF_I, $urandom_range(0, 1) ? rand_triple()
                                       : {3{16'($urandom_range(0, 255))}});
        write_reg(befg_pkg::REG_OFF_J, rand_triple());
        case ($urandom_range(0, 3))
            0: write_reg(befg_pkg::REG_INV_LEN, 48'd0);
            1: write_reg(befg_pkg::REG_INV_LEN, 48'hFFFF_FFFF);
            default: write_reg(befg_pkg::REG_INV_LEN,
                               {16'd0, $urandom_range(0, 32'h0004_0000)});
        endcase
    endtask

    initial begin
        befg_pkg::t_in_beat b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        sink_on = 1;

        // reset config: zero cosines give zero everywhere
        b = rand_beat();
        send_beat(b);
        drain();

        // identity rotation, zero offsets
        write_reg(befg_pkg::REG_ROT_X, {16'd0, 16'd0, 16'h4000});
        write_reg(befg_pkg::REG_ROT_Y, {16'd0, 16'h4000, 16'd0});
        write_reg(befg_pkg::REG_ROT_Z, {16'h4000, 16'd0, 16'd0});
        write_bad_index();
        b = '0;
        send_beat(b);
        b = {11{32'h7FFFFFFF}};
        send_beat(b);
        b = {11{32'h80000000}};
        send_beat(b);
        b = {11{32'hFFFFFFFF}};
        send_beat(b);
        b = '0; b.moment_z_start = 32'h0000_8000;
        send_beat(b);
        b = '0; b.moment_y_end = 32'hFFFF_8000;
        send_beat(b);
        b = '0; b.axial_force = 32'h80000000; b.fixed_axial_start = 32'h7FFFFFFF;
        send_beat(b);
        b = '0; b.torque = 32'h80000000;
        send_beat(b);
        drain();

        // zero reciprocal length, extreme offsets
        write_reg(befg_pkg::REG_INV_LEN, 48'd0);
        write_reg(befg_pkg::REG_OFF_I, {16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(befg_pkg::REG_OFF_J, {16'h8000, 16'h7FFF, 16'h8000});
        b = {11{32'h7FFFFFFF}};
        send_beat(b);
        for (int n = 0; n < 6; n++) send_beat(rand_beat());
        drain();

        // largest reciprocal length, extreme cosines
        write_reg(befg_pkg::REG_INV_LEN, 48'hFFFF_FFFF);
        write_reg(befg_pkg::REG_ROT_X, {3{16'h8000}});
        write_reg(befg_pkg::REG_ROT_Y, {3{16'h7FFF}});
        b = {11{32'h80000000}};
        send_beat(b);
        for (int n = 0; n < 6; n++) send_beat(rand_beat());
        drain();

        // random phases; some run with no gaps on either side
        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            quiet_phase = (phase % 3 == 2);
            for (int n = 0; n < 50; n++) send_beat(rand_beat());
            drain();
        end
        quiet_phase = 0;

        if (!board.failed && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
